FILE: src/tlag_pkg.sv
package tlag_pkg;

  // Largest grid that the row store holds.
  localparam int MAX_COLS = 64;
  localparam int MAX_ROWS = 64;

  // Coordinate, size and address widths.
  localparam int COL_W = $clog2(MAX_COLS);
  localparam int ROW_W = $clog2(MAX_ROWS);
  localparam int DIM_W = 7;
  localparam int ADDR_W = ROW_W + 1;
  localparam int BANK_ROWS = 2 * MAX_ROWS;

  // Neighbor count and the B3/S23 rule.
  localparam int CNT_W = 4;
  localparam logic [CNT_W-1:0] SURVIVE_LOW = CNT_W'(2);
  localparam logic [CNT_W-1:0] SURVIVE_HIGH = CNT_W'(3);
  localparam logic [CNT_W-1:0] BIRTH_COUNT = CNT_W'(3);

  // Command codes carried in s_tuser and echoed in m_tuser.
  typedef enum logic [1:0] {
    CMD_WRITE   = 2'd0,
    CMD_READ    = 2'd1,
    CMD_ADVANCE = 2'd2,
    CMD_NONE    = 2'd3
  } cmd_t;

  // Register indexes of the configuration port.
  localparam logic REG_COLS = 1'b0;
  localparam logic REG_ROWS = 1'b1;

  // Controls for one row update of an advance.
  typedef struct packed {
    logic             en;
    logic             copy_row;
    logic             cols_one;
    logic             rows_one;
    logic [DIM_W-1:0] cols;
  } rule_ctl_t;

endpackage

FILE: src/tlag_row_ram.sv
module tlag_row_ram #(
  parameter int DEPTH = 128,
  parameter int WIDTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one read port with registered read data.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: src/tlag_row_rule.sv
module tlag_row_rule (
  input  logic                        clk,
  input  tlag_pkg::rule_ctl_t         ctl,
  input  logic [tlag_pkg::MAX_COLS-1:0] row_up,
  input  logic [tlag_pkg::MAX_COLS-1:0] row_mid,
  input  logic [tlag_pkg::MAX_COLS-1:0] row_dn,
  output logic [tlag_pkg::MAX_COLS-1:0] next_row
);

  logic [tlag_pkg::MAX_COLS-1:0] next_comb;

  // Count the neighbors of every column of the middle row and apply the rule.
  // A neighbor that wraps back onto the center cell is left out.
  always_comb begin
    logic [tlag_pkg::COL_W-1:0] xl;
    logic [tlag_pkg::COL_W-1:0] xr;
    logic [tlag_pkg::CNT_W-1:0] n;
    next_comb = '0;
    for (int x = 0; x < tlag_pkg::MAX_COLS; x++) begin
      xl = (x == 0) ? tlag_pkg::COL_W'(ctl.cols - tlag_pkg::DIM_W'(1))
                    : tlag_pkg::COL_W'(x - 1);
      xr = (tlag_pkg::DIM_W'(x + 1) >= ctl.cols) ? '0 : tlag_pkg::COL_W'(x + 1);
      n = '0;
      if (!ctl.cols_one) begin
        n = n + tlag_pkg::CNT_W'(row_mid[xl]) + tlag_pkg::CNT_W'(row_mid[xr]);
      end
      if (!ctl.rows_one) begin
        n = n + tlag_pkg::CNT_W'(row_up[x]) + tlag_pkg::CNT_W'(row_dn[x]);
      end
      if (!(ctl.cols_one && ctl.rows_one)) begin
        n = n + tlag_pkg::CNT_W'(row_up[xl]) + tlag_pkg::CNT_W'(row_up[xr])
              + tlag_pkg::CNT_W'(row_dn[xl]) + tlag_pkg::CNT_W'(row_dn[xr]);
      end
      if (ctl.copy_row || (tlag_pkg::DIM_W'(x) >= ctl.cols)) begin
        next_comb[x] = row_mid[x];
      end else if (row_mid[x]) begin
        next_comb[x] = n inside {[tlag_pkg::SURVIVE_LOW:tlag_pkg::SURVIVE_HIGH]};
      end else begin
        next_comb[x] = (n == tlag_pkg::BIRTH_COUNT);
      end
    end
  end

  // Hold the new row for the write-back cycle.
  always_ff @(posedge clk) begin
    if (ctl.en) begin
      next_row <= next_comb;
    end
  end

endmodule

FILE: src/toroidal_life_automaton_grid.sv
// Channel | Direction | Signals                      | Contents
// s       | in        | s_tvalid s_tready s_tdata    | tdata: col, row, alive_in; tuser: cmd
//         |           | s_tuser                      |
// m       | out       | m_tvalid m_tready m_tdata    | tdata: cell_state; tuser: done_cmd
//         |           | m_tuser                      |
// cfg     | in        | cfg_we cfg_index cfg_data    | 0: cols_in_use, 1: rows_in_use
//
// A write or read inside the grid goes through a row read, a modify or select step, then
// the output register; all other items go straight to the output register.
// An advance updates every one of the MAX_ROWS rows of the store in turn: each row
// costs three reads of the single read port, a rule step and a write-back.
// After reset a clearing pass writes all 2 * MAX_ROWS rows first.
// A result that waits for m_tready holds the next item in its hand-off state.
module toroidal_life_automaton_grid (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // col[5:0], row[11:6], alive_in[12], zero pad
  input  logic [1:0]  s_tuser,   // cmd[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // cell_state[0], zero pad
  output logic [1:0]  m_tuser,   // done_cmd[1:0]
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [6:0]  cfg_data
);

  localparam logic [tlag_pkg::DIM_W-1:0] COLS_MAX = tlag_pkg::DIM_W'(tlag_pkg::MAX_COLS);
  localparam logic [tlag_pkg::DIM_W-1:0] ROWS_MAX = tlag_pkg::DIM_W'(tlag_pkg::MAX_ROWS);
  localparam logic [tlag_pkg::ROW_W-1:0] ROW_LAST = tlag_pkg::ROW_W'(tlag_pkg::MAX_ROWS - 1);
  localparam logic [tlag_pkg::ADDR_W-1:0] CLR_LAST =
    tlag_pkg::ADDR_W'(tlag_pkg::BANK_ROWS - 1);

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_CELL_RD,
    S_CELL_MOD,
    S_ADV_RD0,
    S_ADV_RD1,
    S_ADV_RD2,
    S_ADV_CALC,
    S_ADV_WR,
    S_PUSH
  } state_t;

  state_t state;

  logic [tlag_pkg::DIM_W-1:0] cols_in_use;
  logic [tlag_pkg::DIM_W-1:0] rows_in_use;
  logic [tlag_pkg::DIM_W-1:0] cols_eff;
  logic [tlag_pkg::DIM_W-1:0] rows_eff;

  logic                       cur_bank;
  logic [tlag_pkg::ADDR_W-1:0] clr_cnt;
  logic [tlag_pkg::ROW_W-1:0] adv_row;
  logic [tlag_pkg::ROW_W-1:0] row_above;
  logic [tlag_pkg::ROW_W-1:0] row_below;

  logic [1:0]                 cmd_q;
  logic [tlag_pkg::COL_W-1:0] col_q;
  logic [tlag_pkg::ROW_W-1:0] row_q;
  logic                       alive_q;
  logic                       res_cell;

  logic [tlag_pkg::MAX_COLS-1:0] row_up;
  logic [tlag_pkg::MAX_COLS-1:0] row_mid;
  logic [tlag_pkg::MAX_COLS-1:0] rule_row;
  logic [tlag_pkg::MAX_COLS-1:0] cell_mask;

  logic                          ram_we;
  logic [tlag_pkg::ADDR_W-1:0]   ram_waddr;
  logic [tlag_pkg::MAX_COLS-1:0] ram_wdata;
  logic [tlag_pkg::ADDR_W-1:0]   ram_raddr;
  logic [tlag_pkg::MAX_COLS-1:0] ram_rdata;

  tlag_pkg::rule_ctl_t rule_ctl;

  logic                       in_xfer;
  logic [1:0]                 in_cmd;
  logic [tlag_pkg::COL_W-1:0] in_col;
  logic [tlag_pkg::ROW_W-1:0] in_row;
  logic                       in_inside;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cols_in_use <= COLS_MAX;
      rows_in_use <= ROWS_MAX;
    end else if (cfg_we) begin
      if (cfg_index == tlag_pkg::REG_COLS) begin
        cols_in_use <= cfg_data;
      end
      if (cfg_index == tlag_pkg::REG_ROWS) begin
        rows_in_use <= cfg_data;
      end
    end
  end

  // Sizes in use: zero counts as one, anything above the store as the store.
  assign cols_eff = (cols_in_use == '0) ? tlag_pkg::DIM_W'(1) :
                    (cols_in_use > COLS_MAX) ? COLS_MAX : cols_in_use;
  assign rows_eff = (rows_in_use == '0) ? tlag_pkg::DIM_W'(1) :
                    (rows_in_use > ROWS_MAX) ? ROWS_MAX : rows_in_use;

  // Input transaction fields.
  assign s_tready = (state == S_IDLE);
  assign in_xfer = s_tvalid && s_tready;
  assign in_cmd = s_tuser;
  assign in_col = s_tdata[tlag_pkg::COL_W-1:0];
  assign in_row = s_tdata[tlag_pkg::COL_W +: tlag_pkg::ROW_W];
  assign in_inside = (tlag_pkg::DIM_W'(in_col) < cols_eff) &&
                     (tlag_pkg::DIM_W'(in_row) < rows_eff);

  // Wrapped row neighbors of the row being advanced.
  assign row_above = (adv_row == '0) ? tlag_pkg::ROW_W'(rows_eff - tlag_pkg::DIM_W'(1))
                                     : adv_row - tlag_pkg::ROW_W'(1);
  assign row_below = ((tlag_pkg::DIM_W'(adv_row) + tlag_pkg::DIM_W'(1)) >= rows_eff)
                     ? '0 : adv_row + tlag_pkg::ROW_W'(1);

  assign cell_mask = tlag_pkg::MAX_COLS'(1) << col_q;

  // Read port: the current bank at the row each state needs.
  always_comb begin
    case (state)
      S_CELL_RD: ram_raddr = {cur_bank, row_q};
      S_ADV_RD0: ram_raddr = {cur_bank, row_above};
      S_ADV_RD2: ram_raddr = {cur_bank, row_below};
      default:   ram_raddr = {cur_bank, adv_row};
    endcase
  end

  // Write port: clearing pass, single-cell update or new-generation row.
  always_comb begin
    ram_we = 1'b0;
    ram_waddr = clr_cnt;
    ram_wdata = '0;
    case (state)
      S_CLEAR: begin
        ram_we = 1'b1;
      end
      S_CELL_MOD: begin
        ram_we = (cmd_q == tlag_pkg::CMD_WRITE);
        ram_waddr = {cur_bank, row_q};
        ram_wdata = (ram_rdata & ~cell_mask) | (alive_q ? cell_mask : '0);
      end
      S_ADV_WR: begin
        ram_we = 1'b1;
        ram_waddr = {~cur_bank, adv_row};
        ram_wdata = rule_row;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  tlag_row_ram #(
    .DEPTH(tlag_pkg::BANK_ROWS),
    .WIDTH(tlag_pkg::MAX_COLS)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // The lower row arrives from the store in the calculation cycle.
  always_comb begin
    rule_ctl.en = (state == S_ADV_CALC);
    rule_ctl.copy_row = (tlag_pkg::DIM_W'(adv_row) >= rows_eff);
    rule_ctl.cols_one = (cols_eff == tlag_pkg::DIM_W'(1));
    rule_ctl.rows_one = (rows_eff == tlag_pkg::DIM_W'(1));
    rule_ctl.cols = cols_eff;
  end

  tlag_row_rule u_rule (
    .clk     (clk),
    .ctl     (rule_ctl),
    .row_up  (row_up),
    .row_mid (row_mid),
    .row_dn  (ram_rdata),
    .next_row(rule_row)
  );

  // Sequencer and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      clr_cnt <= '0;
      cur_bank <= 1'b0;
      adv_row <= '0;
      m_tvalid <= 1'b0;
    end else begin
      // The hand-off state reloads the output register itself.
      if (m_tvalid && m_tready && (state != S_PUSH)) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          clr_cnt <= clr_cnt + tlag_pkg::ADDR_W'(1);
          if (clr_cnt == CLR_LAST) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_xfer) begin
            cmd_q <= in_cmd;
            col_q <= in_col;
            row_q <= in_row;
            alive_q <= s_tdata[tlag_pkg::COL_W + tlag_pkg::ROW_W];
            res_cell <= 1'b0;
            adv_row <= '0;
            if (in_cmd == tlag_pkg::CMD_ADVANCE) begin
              state <= S_ADV_RD0;
            end else if ((in_cmd inside {tlag_pkg::CMD_WRITE, tlag_pkg::CMD_READ})
                         && in_inside) begin
              state <= S_CELL_RD;
            end else begin
              state <= S_PUSH;
            end
          end
        end
        S_CELL_RD: begin
          state <= S_CELL_MOD;
        end
        S_CELL_MOD: begin
          if (cmd_q == tlag_pkg::CMD_READ) begin
            res_cell <= ram_rdata[col_q];
          end
          state <= S_PUSH;
        end
        S_ADV_RD0: begin
          state <= S_ADV_RD1;
        end
        S_ADV_RD1: begin
          row_up <= ram_rdata;
          state <= S_ADV_RD2;
        end
        S_ADV_RD2: begin
          row_mid <= ram_rdata;
          state <= S_ADV_CALC;
        end
        S_ADV_CALC: begin
          state <= S_ADV_WR;
        end
        S_ADV_WR: begin
          if (adv_row == ROW_LAST) begin
            cur_bank <= ~cur_bank;
            state <= S_PUSH;
          end else begin
            adv_row <= adv_row + tlag_pkg::ROW_W'(1);
            state <= S_ADV_RD0;
          end
        end
        S_PUSH: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata <= {7'b0, res_cell};
            m_tuser <= cmd_q;
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // An accepted item keeps the input closed in the following cycle.
  assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input accepted in two consecutive cycles");

  // A new result appears only from the result hand-off state.
  assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state == S_PUSH))
    else $error("result raised outside the hand-off state");

  // New-generation rows never land in the bank being read.
  assert property (@(posedge clk) disable iff (rst)
    (state == S_ADV_WR) |-> (ram_waddr[tlag_pkg::ADDR_W-1] != cur_bank))
    else $error("advance writes into the current bank");

  // The banks swap only at the end of an advance.
  assert property (@(posedge clk) disable iff (rst)
    $past(!rst) && (cur_bank != $past(cur_bank)) |-> $past(state == S_ADV_WR))
    else $error("bank swapped outside an advance");

endmodule
